// ===== hdl/srce_pkg.sv =====
package srce_pkg;

  localparam int unsigned NumRegsDef = 4;
  localparam int unsigned DataStackDepthDef = 16;
  localparam int unsigned CallStackDepthDef = 16;
  localparam int unsigned DataW = 32;

  typedef enum logic [4:0] {
    OP_EXIT  = 5'd0,  OP_PUSH  = 5'd1,  OP_POP   = 5'd2,  OP_ADD_S = 5'd3,
    OP_SUB_S = 5'd4,  OP_MUL_S = 5'd5,  OP_DIV_S = 5'd6,  OP_NEG   = 5'd7,
    OP_ADD   = 5'd8,  OP_SUB   = 5'd9,  OP_MUL   = 5'd10, OP_DIV   = 5'd11,
    OP_ADDI  = 5'd12, OP_SUBI  = 5'd13, OP_MULI  = 5'd14, OP_DIVI  = 5'd15,
    OP_B     = 5'd16, OP_RET   = 5'd17, OP_BL    = 5'd18, OP_BEQ   = 5'd19,
    OP_BNE   = 5'd20, OP_BGE   = 5'd21, OP_BLT   = 5'd22, OP_READ  = 5'd23,
    OP_WRITE = 5'd24
  } op_e;

  typedef enum logic [1:0] {
    FAULT_NONE       = 2'd0,
    FAULT_DATA_UNDER = 2'd1,
    FAULT_CALL_UNDER = 2'd2,
    FAULT_OVER       = 2'd3
  } fault_e;

  typedef struct packed {
    logic [4:0]  op;
    logic [1:0]  reg_a;
    logic [1:0]  reg_b;
    logic [1:0]  reg_c;
    logic [31:0] imm;
    logic [31:0] read_value;
  } in_req_t;

  typedef struct packed {
    logic [31:0] next_pc;
    logic        running;
    logic        write_valid;
    logic [1:0]  write_reg;
    logic [31:0] write_value;
    logic [1:0]  fault;
  } out_req_t;

  // controller to datapath
  typedef struct packed {
    logic load;     // capture request, read operands
    logic exec;     // run a non-divide op or finish a divide
    logic div_step; // load the divider or run one restoring-divide iteration
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic need_div; // captured request takes the divider
    logic div_last; // final iteration this cycle
  } sts_t;

endpackage

// ===== hdl/srce_ctrl.sv =====
module srce_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output srce_pkg::cmd_t  cmd_o,
  input  srce_pkg::sts_t  sts_i
);
  import srce_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_OPER = 4'b0010,
    ST_DIV  = 4'b0100,
    ST_DONE = 4'b1000
  } state_e;

  state_e state_q, state_d;
  logic   accept;

  // output register empties into the next request
  assign in_ready_o  = (state_q == ST_IDLE) || (state_q == ST_DONE && out_ready_i);
  assign out_valid_o = (state_q == ST_DONE);
  assign accept      = in_valid_i && in_ready_o;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE, ST_DONE: begin
        if (accept) begin
          cmd_o.load = 1'b1;
          state_d    = ST_OPER;
        end else if (state_q == ST_DONE && out_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      ST_OPER: begin
        if (sts_i.need_div) begin
          state_d = ST_DIV;
        end else begin
          cmd_o.exec = 1'b1;
          state_d    = ST_DONE;
        end
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) begin
          cmd_o.exec = 1'b1;
          state_d    = ST_DONE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== hdl/srce_dpath.sv =====
module srce_dpath #(
  parameter int unsigned NUM_REGS         = srce_pkg::NumRegsDef,
  parameter int unsigned DATA_STACK_DEPTH = srce_pkg::DataStackDepthDef,
  parameter int unsigned CALL_STACK_DEPTH = srce_pkg::CallStackDepthDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  srce_pkg::in_req_t  in_req_i,
  input  srce_pkg::cmd_t     cmd_i,
  output srce_pkg::sts_t     sts_o,
  output srce_pkg::out_req_t out_req_o
);
  import srce_pkg::*;

  localparam int unsigned DsAw = (DATA_STACK_DEPTH > 1) ? $clog2(DATA_STACK_DEPTH) : 1;
  localparam int unsigned CsAw = (CALL_STACK_DEPTH > 1) ? $clog2(CALL_STACK_DEPTH) : 1;
  localparam int unsigned DsCw = $clog2(DATA_STACK_DEPTH + 1);
  localparam int unsigned CsCw = $clog2(CALL_STACK_DEPTH + 1);
  localparam logic [DsCw-1:0] DsFull = DsCw'(DATA_STACK_DEPTH);
  localparam logic [CsCw-1:0] CsFull = CsCw'(CALL_STACK_DEPTH);

  logic [DataW-1:0] regs_q [NUM_REGS];
  logic [DataW-1:0] ds_mem [DATA_STACK_DEPTH];
  logic [DataW-1:0] cs_mem [CALL_STACK_DEPTH];
  logic [DataW-1:0] pc_q;
  logic             run_q;
  logic [DsCw-1:0]  ds_cnt_q;
  logic [CsCw-1:0]  cs_cnt_q;

  in_req_t          req_q;
  logic [DataW-1:0] ra_q, rb_q, rc_q, top_q, sec_q, cs_top_q;
  logic [DataW-1:0] dvd_q, dvs_q, rem_q;
  logic [5:0]       div_cnt_q;
  out_req_t         out_q, out_d;

  function automatic logic [DataW-1:0] rd(input logic [1:0] idx,
                                          input logic [DataW-1:0] r [NUM_REGS]);
    logic [DataW-1:0] v;
    v = '0;
    for (int i = 0; i < NUM_REGS; i++) begin
      if (32'(idx) == i) v = r[i];
    end
    return v;
  endfunction

  // read operands and stack tops at capture
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_q    <= in_req_i;
      ra_q     <= rd(in_req_i.reg_a, regs_q);
      rb_q     <= rd(in_req_i.reg_b, regs_q);
      rc_q     <= rd(in_req_i.reg_c, regs_q);
      top_q    <= ds_mem[DsAw'(ds_cnt_q - DsCw'(1))];
      sec_q    <= ds_mem[DsAw'(ds_cnt_q - DsCw'(2))];
      cs_top_q <= cs_mem[CsAw'(cs_cnt_q - CsCw'(1))];
    end
  end

  op_e op;
  logic is_div, two_on_stack;
  assign op           = op_e'(req_q.op);
  assign two_on_stack = ds_cnt_q >= DsCw'(2);
  assign is_div       = run_q && ((op == OP_DIV_S && two_on_stack) || op == OP_DIV ||
                                  op == OP_DIVI);

  logic [DataW-1:0] div_n, div_d;
  always_comb begin
    div_n = rb_q;
    div_d = rc_q;
    if (op == OP_DIV_S) begin
      div_n = sec_q;
      div_d = top_q;
    end else if (op == OP_DIVI) begin
      div_d = req_q.imm;
    end
  end

  // restoring divider, one quotient bit a cycle
  logic [DataW:0]   rem_sh, rem_sub;
  logic [DataW-1:0] quot;
  assign rem_sh  = {rem_q, dvd_q[DataW-1]};
  assign rem_sub = rem_sh - {1'b0, dvs_q};
  assign quot    = (dvs_q == '0) ? '1 : {dvd_q[DataW-2:0], ~rem_sub[DataW]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_cnt_q <= '0;
    end else if (cmd_i.div_step) begin
      div_cnt_q <= div_cnt_q + 6'd1;
    end else begin
      div_cnt_q <= '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_step) begin
      if (div_cnt_q == 6'd0) begin
        dvd_q <= div_n;
        dvs_q <= div_d;
        rem_q <= '0;
      end else begin
        rem_q <= rem_sub[DataW] ? rem_sh[DataW-1:0] : rem_sub[DataW-1:0];
        dvd_q <= {dvd_q[DataW-2:0], ~rem_sub[DataW]};
      end
    end
  end

  assign sts_o.need_div = is_div;
  assign sts_o.div_last = (div_cnt_q == 6'(DataW));

  // execute and update architectural state
  logic [DataW-1:0] pc1, nxt, wdata, mul_a, mul_b, mul_p, stack_res;
  logic             wen, ds_push, ds_pop, ds_bin, cs_push, cs_pop, halt;
  fault_e           flt;

  assign pc1   = pc_q + 32'd1;
  assign mul_a = (op == OP_MUL_S) ? sec_q : rb_q;
  assign mul_b = (op == OP_MUL_S) ? top_q : ((op == OP_MULI) ? req_q.imm : rc_q);
  assign mul_p = mul_a * mul_b;

  always_comb begin
    nxt = pc1; wdata = '0; wen = 1'b0; flt = FAULT_NONE; halt = 1'b0;
    ds_push = 1'b0; ds_pop = 1'b0; ds_bin = 1'b0; cs_push = 1'b0; cs_pop = 1'b0;
    stack_res = '0;
    unique case (op)
      OP_EXIT: halt = 1'b1;
      OP_PUSH: if (ds_cnt_q >= DsFull) flt = FAULT_OVER; else ds_push = 1'b1;
      OP_POP: begin
        if (ds_cnt_q == '0) flt = FAULT_DATA_UNDER;
        else begin ds_pop = 1'b1; wen = 1'b1; wdata = top_q; end
      end
      OP_ADD_S, OP_SUB_S, OP_MUL_S, OP_DIV_S: begin
        if (!two_on_stack) flt = FAULT_DATA_UNDER;
        else begin
          ds_bin = 1'b1;
          unique case (op)
            OP_ADD_S: stack_res = sec_q + top_q;
            OP_SUB_S: stack_res = sec_q - top_q;
            OP_MUL_S: stack_res = mul_p;
            default:  stack_res = quot;
          endcase
        end
      end
      OP_NEG:  begin wen = 1'b1; wdata = 32'd0 - ra_q; end
      OP_ADD:  begin wen = 1'b1; wdata = rb_q + rc_q; end
      OP_SUB:  begin wen = 1'b1; wdata = rb_q - rc_q; end
      OP_ADDI: begin wen = 1'b1; wdata = rb_q + req_q.imm; end
      OP_SUBI: begin wen = 1'b1; wdata = rb_q - req_q.imm; end
      OP_MUL, OP_MULI: begin wen = 1'b1; wdata = mul_p; end
      OP_DIV, OP_DIVI: begin wen = 1'b1; wdata = quot; end
      OP_B: nxt = req_q.imm;
      OP_RET: if (cs_cnt_q == '0) flt = FAULT_CALL_UNDER;
              else begin cs_pop = 1'b1; nxt = cs_top_q; end
      OP_BL: if (cs_cnt_q >= CsFull) flt = FAULT_OVER;
             else begin cs_push = 1'b1; nxt = req_q.imm; end
      OP_BEQ: if (ra_q == rb_q) nxt = req_q.imm;
      OP_BNE: if (ra_q != rb_q) nxt = req_q.imm;
      OP_BGE: if (ra_q >= rb_q) nxt = req_q.imm;
      OP_BLT: if (ra_q <  rb_q) nxt = req_q.imm;
      OP_READ: begin wen = 1'b1; wdata = req_q.read_value; end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q     <= 32'd1;
      run_q    <= 1'b1;
      ds_cnt_q <= '0;
      cs_cnt_q <= '0;
      for (int i = 0; i < NUM_REGS; i++) regs_q[i] <= '0;
    end else if (cmd_i.exec && run_q) begin
      pc_q <= nxt;
      if (halt || flt != FAULT_NONE) run_q <= 1'b0;
      if (ds_push) ds_cnt_q <= ds_cnt_q + DsCw'(1);
      if (ds_pop || ds_bin) ds_cnt_q <= ds_cnt_q - DsCw'(1);
      if (cs_push) cs_cnt_q <= cs_cnt_q + CsCw'(1);
      if (cs_pop)  cs_cnt_q <= cs_cnt_q - CsCw'(1);
      for (int i = 0; i < NUM_REGS; i++) begin
        if (wen && 32'(req_q.reg_a) == i) regs_q[i] <= wdata;
      end
    end
  end

  // stack memories
  always_ff @(posedge clk_i) begin
    if (cmd_i.exec && run_q) begin
      if (ds_push) ds_mem[DsAw'(ds_cnt_q)] <= req_q.imm;
      if (ds_bin)  ds_mem[DsAw'(ds_cnt_q - DsCw'(2))] <= stack_res;
      if (cs_push) cs_mem[CsAw'(cs_cnt_q)] <= pc1;
    end
  end

  // assemble the result
  always_comb begin
    out_d = '0;
    if (!run_q) begin
      out_d.next_pc = pc_q;
    end else begin
      out_d.next_pc = nxt;
      out_d.running = !(halt || flt != FAULT_NONE);
      out_d.fault   = flt;
      if (op == OP_WRITE) begin
        out_d.write_valid = 1'b1;
        out_d.write_reg   = req_q.reg_a;
        out_d.write_value = ra_q;
      end
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      out_q <= out_d;
    end
  end

  assign out_req_o = out_q;

endmodule

// ===== hdl/stack_register_cpu_execute.sv =====
// Each request is captured with its operands, then executed; a new request
// enters only once the last result is in the output register. The bit-serial
// restoring divider takes one quotient bit each cycle.
// A finished result waits in the output register; the next request can enter as it is taken.
// Reset (rst_ni low, asynchronous): registers 0, pc 1, machine running,
// both stacks empty.
module stack_register_cpu_execute #(
  parameter int unsigned NUM_REGS         = srce_pkg::NumRegsDef,
  parameter int unsigned DATA_STACK_DEPTH = srce_pkg::DataStackDepthDef,
  parameter int unsigned CALL_STACK_DEPTH = srce_pkg::CallStackDepthDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  srce_pkg::in_req_t  in_req_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output srce_pkg::out_req_t out_req_o
);
  import srce_pkg::*;

  cmd_t cmd;
  sts_t sts;

  srce_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .out_valid_o, .out_ready_i,
    .cmd_o(cmd), .sts_i(sts)
  );

  srce_dpath #(
    .NUM_REGS(NUM_REGS), .DATA_STACK_DEPTH(DATA_STACK_DEPTH),
    .CALL_STACK_DEPTH(CALL_STACK_DEPTH)
  ) u_dpath (
    .clk_i, .rst_ni, .in_req_i, .cmd_i(cmd), .sts_o(sts), .out_req_o
  );

endmodule

// ===== hdl/srce_checker.sv =====
module srce_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_i,
  input logic               out_valid_i,
  input logic               out_ready_i,
  input srce_pkg::out_req_t out_req_i
);
  import srce_pkg::*;

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_req_i))
    else $error("result changed while stalled");

  // report only on a running machine without fault
  a_write_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_req_i.write_valid |-> out_req_i.running &&
    out_req_i.fault == FAULT_NONE)
    else $error("write report on halted machine");

  // a fault always halts
  a_fault_halt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_req_i.fault != FAULT_NONE |-> !out_req_i.running)
    else $error("fault without halt");

  // ready drops in the cycle after a request enters
  a_no_bypass: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("ready right after request");

endmodule

bind stack_register_cpu_execute srce_checker u_srce_checker (
  .clk_i, .rst_ni, .in_valid_i, .in_ready_i(in_ready_o), .out_valid_i(out_valid_o),
  .out_ready_i, .out_req_i(out_req_o)
);
